FILE: rtl/core/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// double_ended_queue_assert: assertion macros for the double-ended queue.
// Each macro is empty when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types, codes and helpers of the double-ended queue.
// Holds the queue geometry, the command and status codes and the item types.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Queue geometry.
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Command codes.
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [1:0] CMD_POP_BACK   = 2'd1;
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd2;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [6:0]         count;
  } result_t;

  // A pushed value is kept as its low DATA_WIDTH bits after sign extension.
  function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  // A stored entry leaves sign-extended and cut to 32 bits.
  function automatic logic signed [31:0] to_out(input logic [DATA_WIDTH-1:0] d);
    logic signed [63:0] ext;
    ext = 64'(signed'(d));
    return ext[31:0];
  endfunction

  // Ring index step forward, wrapping at DEPTH.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  // Ring index step back, wrapping at zero.
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

FILE: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue in a ring-buffer memory.
// Timing: the result item of an accepted item is strobed in the cycle after it.
// Throughput: one item per cycle while busy is low; each item makes at most one memory access.
// Reset: rst clears the indices and the count; busy is high during reset.
// The receiver cannot stall: each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::request_t request,
  output logic              done,
  output deq_pkg::result_t  result
);

  localparam int IW = deq_pkg::IDX_W;
  localparam int CW = deq_pkg::CNT_W;
  localparam int DW = deq_pkg::DATA_WIDTH;

  // Element memory; contents are undefined until written.
  logic [DW-1:0] mem [deq_pkg::DEPTH];
  logic [DW-1:0] rd_data;

  logic [IW-1:0] front_idx, front_idx_next;
  logic [IW-1:0] back_idx, back_idx_next;
  logic [CW-1:0] cnt, cnt_next;

  logic          pop_ok;
  logic [1:0]    status;
  logic [1:0]    status_next;

  logic          accept;
  logic          full;
  logic          empty;
  logic          wr_en;
  logic          rd_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  // Nothing is taken while reset holds; otherwise every cycle is open.
  assign busy   = rst;
  assign accept = start && !busy;

  assign full    = (cnt == CW'(deq_pkg::DEPTH));
  assign empty   = (cnt == '0);

  // Decode the operation into index updates and at most one memory access.
  always_comb begin
    front_idx_next = front_idx;
    back_idx_next  = back_idx;
    cnt_next       = cnt;
    status_next    = deq_pkg::ST_OK;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = back_idx;
    rd_addr        = front_idx;
    if (accept) begin
      case (request.cmd)
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = back_idx;
            back_idx_next = deq_pkg::idx_inc(back_idx);
            cnt_next      = cnt + CW'(1);
          end
        end
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = deq_pkg::ST_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = deq_pkg::idx_dec(front_idx);
            front_idx_next = deq_pkg::idx_dec(front_idx);
            cnt_next       = cnt + CW'(1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = deq_pkg::idx_dec(back_idx);
            back_idx_next = deq_pkg::idx_dec(back_idx);
            cnt_next      = cnt - CW'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_next = deq_pkg::ST_EMPTY;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = front_idx;
            front_idx_next = deq_pkg::idx_inc(front_idx);
            cnt_next       = cnt - CW'(1);
          end
        end
        default: begin
          status_next = deq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Memory port: an item either writes or reads, never both, so the registered
  // read of a pop always sees every earlier push.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= deq_pkg::to_store(request.value);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Queue indices, element count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx <= '0;
      back_idx  <= '0;
      cnt       <= '0;
      done      <= 1'b0;
    end else begin
      front_idx <= front_idx_next;
      back_idx  <= back_idx_next;
      cnt       <= cnt_next;
      done      <= accept;
    end
  end

  // Result fields that ride alongside the memory read.
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_ok <= rd_en;
      status <= status_next;
    end
  end

  // Pushes and failed pops return zero; a good pop returns the entry read.
  always_comb begin
    result.value_out = pop_ok ? deq_pkg::to_out(rd_data) : 32'sd0;
    result.status    = status;
    result.count     = 7'(cnt);
  end

  // Each accepted item yields exactly one result in the next cycle.
  `DEQ_ASSERT_NEXT(a_accept_done, clk, rst, accept, done, "accepted item gave no result")
  `DEQ_ASSERT_NEXT(a_no_spurious, clk, rst, !accept, !done, "result without an item")
  // A dropped push only happens with the queue holding DEPTH elements.
  `DEQ_ASSERT_NOW(a_full_count, clk, rst, done && (result.status == deq_pkg::ST_FULL),
    cnt == CW'(deq_pkg::DEPTH), "full status with queue not full")
  // A pop from an empty queue returns zero and leaves it empty.
  `DEQ_ASSERT_NOW(a_empty_zero, clk, rst, done && (result.status == deq_pkg::ST_EMPTY),
    (result.value_out == 32'sd0) && (cnt == '0), "empty pop returned data")

endmodule
